// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the velocity update blocks
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define VTSU_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define VTSU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- rtl/vtsu_pkg.sv -----
// ----------------------------------------------------------------------------
// vtsu_pkg
// widths, codes, constants and helper functions of the velocity update
// ----------------------------------------------------------------------------
package vtsu_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int RHO_W      = DATA_WIDTH - 1;
    localparam int WIDE_W     = 64;
    // quotient bits needed for a (DATA_WIDTH+1)-bit numerator shifted by FRAC_BITS
    localparam int QUO_W      = DATA_WIDTH + FRAC_BITS + 1;
    localparam int ADDR_W     = 5;

    localparam logic [2:0] STEP_PRED = 3'd0;
    localparam logic [2:0] STEP_CORR = 3'd1;
    localparam logic [2:0] STEP_RK1  = 3'd2;
    localparam logic [2:0] STEP_RK2  = 3'd3;
    localparam logic [2:0] STEP_RK3  = 3'd4;

    localparam logic [1:0] DIFF_EXPL = 2'd0;
    localparam logic [1:0] DIFF_CN   = 2'd1;

    localparam logic [2:0] REG_STEP   = 3'd0;
    localparam logic [2:0] REG_DIFF   = 3'd1;
    localparam logic [2:0] REG_ADV    = 3'd2;
    localparam logic [2:0] REG_TENSOR = 3'd3;
    localparam logic [2:0] REG_DT     = 3'd4;

    localparam logic [RHO_W-1:0] DT_RESET        = RHO_W'(655);
    localparam logic [RHO_W-1:0] Q_ONE           = RHO_W'(1 << FRAC_BITS);
    localparam logic [RHO_W-1:0] Q_QUARTER       = RHO_W'((1 << FRAC_BITS) / 4);
    localparam logic [RHO_W-1:0] Q_THREE_QUARTER = RHO_W'(3 * ((1 << FRAC_BITS) / 4));
    localparam logic [RHO_W-1:0] Q_THIRD         = RHO_W'(((1 << FRAC_BITS) + 1) / 3);
    localparam logic [RHO_W-1:0] Q_TWO_THIRDS    = RHO_W'((2 * (1 << FRAC_BITS) + 1) / 3);

    typedef logic signed [WIDE_W-1:0]     t_wide;
    typedef logic signed [DATA_WIDTH-1:0] t_data;
    typedef logic [RHO_W-1:0]             t_rho;

    localparam t_wide WIDE_MAX = {1'b0, {(WIDE_W-1){1'b1}}};
    localparam t_wide WIDE_MIN = {1'b1, {(WIDE_W-1){1'b0}}};

    typedef struct packed {
        logic  ov;
        t_wide v;
    } t_sat;

    // item context that travels beside the datapath
    typedef struct packed {
        logic  rk3;
        logic  bypass;
        t_wide base;
        t_wide sum;
        t_data frc;
        t_rho  kdt;
        t_rho  den;
        logic  ov;
        logic  zd;
    } t_ctx;

    function automatic t_sat sat_add(t_wide a, t_wide b);
        logic signed [WIDE_W:0] s;
        t_sat r;
        s = {a[WIDE_W-1], a} + {b[WIDE_W-1], b};
        if (s[WIDE_W] != s[WIDE_W-1]) begin
            r.ov = 1'b1;
            r.v  = s[WIDE_W] ? WIDE_MIN : WIDE_MAX;
        end else begin
            r.ov = 1'b0;
            r.v  = s[WIDE_W-1:0];
        end
        return r;
    endfunction

    // half of x, truncated toward zero
    function automatic t_wide half_q(t_wide x);
        t_wide r;
        r = (x + t_wide'({1'b0, x[WIDE_W-1]})) >>> 1;
        return r;
    endfunction

endpackage

// ----- rtl/vtsu_in_if.sv -----
// ----------------------------------------------------------------------------
// vtsu_in_if
// input channel of the velocity update: one cell component per transaction
// ----------------------------------------------------------------------------
interface vtsu_in_if;
    import vtsu_pkg::*;

    logic  valid;
    logic  ready;
    t_data vel_now;
    t_data vel_prev;
    t_data conv_prev;
    t_data conv_next;
    t_data force_term;
    t_data diff_prev;
    t_data diff_next;
    t_rho  rho_prev;
    t_rho  rho_next;
    t_rho  rho_half;

    modport source (
        output valid, vel_now, vel_prev, conv_prev, conv_next, force_term,
               diff_prev, diff_next, rho_prev, rho_next, rho_half,
        input  ready
    );
    modport sink (
        input  valid, vel_now, vel_prev, conv_prev, conv_next, force_term,
               diff_prev, diff_next, rho_prev, rho_next, rho_half,
        output ready
    );
endinterface

// ----- rtl/vtsu_out_if.sv -----
// ----------------------------------------------------------------------------
// vtsu_out_if
// result channel of the velocity update
// ----------------------------------------------------------------------------
interface vtsu_out_if;
    import vtsu_pkg::*;

    logic  valid;
    logic  ready;
    t_data vel_result;
    logic  zero_density;
    logic  saturated;

    modport source (output valid, vel_result, zero_density, saturated, input ready);
    modport sink   (input valid, vel_result, zero_density, saturated, output ready);
endinterface

// ----- rtl/vtsu_mul.sv -----
// ----------------------------------------------------------------------------
// vtsu_mul
// two-stage fixed point multiplier, unsigned by signed, saturating to 64 bits
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module vtsu_mul (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  vtsu_pkg::t_rho  i_a,
    input  vtsu_pkg::t_wide i_b,
    output vtsu_pkg::t_wide o_p,
    output logic           o_ov
);
    import vtsu_pkg::*;

    localparam int PP_W   = RHO_W + 32;
    localparam int FULL_W = PP_W + 32;
    localparam int SH_W   = FULL_W - FRAC_BITS;

    logic [WIDE_W-1:0] mag;
    logic [PP_W-1:0]   r_plo, r_phi;
    logic              r_neg;
    logic [FULL_W-1:0] full;
    logic [SH_W-1:0]   sh, lim;
    t_wide             n_p, r_p;
    logic              n_ov, r_ov;

    assign mag = i_b[WIDE_W-1] ? WIDE_W'(-i_b) : WIDE_W'(i_b);

    // partial products split at bit 32 of the magnitude
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_plo <= i_a * mag[31:0];
            r_phi <= i_a * mag[WIDE_W-1:32];
            r_neg <= i_b[WIDE_W-1];
        end
    end

    always_comb begin
        full = {r_phi, 32'b0} + FULL_W'(r_plo);
        sh   = full[FULL_W-1:FRAC_BITS];
        lim  = r_neg ? (SH_W'(1) << (WIDE_W-1)) : ((SH_W'(1) << (WIDE_W-1)) - SH_W'(1));
        if (sh > lim) begin
            n_ov = 1'b1;
            n_p  = r_neg ? WIDE_MIN : WIDE_MAX;
        end else begin
            n_ov = 1'b0;
            n_p  = r_neg ? -t_wide'(sh[WIDE_W-1:0]) : t_wide'(sh[WIDE_W-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p  <= n_p;
            r_ov <= n_ov;
        end
    end

    assign o_p  = r_p;
    assign o_ov = r_ov;

    `VTSU_ASSERT_IMP(a_mul_sat_extreme, i_clk, i_rst_n, r_ov, (r_p == WIDE_MAX) || (r_p == WIDE_MIN))
endmodule

// ----- rtl/vtsu_div.sv -----
// ----------------------------------------------------------------------------
// vtsu_div
// pipelined restoring divider, one quotient bit per stage, fixed point
// quotient (num << FRAC_BITS) / den with saturation and zero divisor flag
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module vtsu_div (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  logic            i_do,
    input  vtsu_pkg::t_wide i_num,
    input  vtsu_pkg::t_rho  i_den,
    input  vtsu_pkg::t_ctx  i_ctx,
    output logic            o_valid,
    output vtsu_pkg::t_wide o_q,
    output logic            o_zd,
    output logic            o_ov,
    output vtsu_pkg::t_ctx  o_ctx
);
    import vtsu_pkg::*;

    localparam int LOW_W = QUO_W - FRAC_BITS;

    logic [WIDE_W-1:0] mag;
    logic              ovf0;

    logic             r_v    [0:QUO_W];
    logic [RHO_W-1:0] r_rem  [0:QUO_W];
    logic [QUO_W-1:0] r_quo  [0:QUO_W];
    logic [LOW_W-1:0] r_low  [0:QUO_W];
    t_rho             r_den  [0:QUO_W];
    logic             r_neg  [0:QUO_W];
    logic             r_zero [0:QUO_W];
    logic             r_ovf  [0:QUO_W];
    logic             r_do   [0:QUO_W];
    t_wide            r_num  [0:QUO_W];
    t_ctx             r_ctx  [0:QUO_W];

    logic  r_o_valid, r_o_zd, r_o_ov;
    t_wide r_o_q;
    t_ctx  r_o_ctx;
    t_wide n_q;
    logic  n_zd, n_ov;

    assign mag  = i_num[WIDE_W-1] ? WIDE_W'(-i_num) : WIDE_W'(i_num);
    assign ovf0 = mag[WIDE_W-1:LOW_W] >= i_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= ovf0 ? '0 : mag[WIDE_W-1:LOW_W];
            r_quo[0]  <= '0;
            r_low[0]  <= mag[LOW_W-1:0];
            r_den[0]  <= i_den;
            r_neg[0]  <= i_num[WIDE_W-1];
            r_zero[0] <= i_den == '0;
            r_ovf[0]  <= ovf0;
            r_do[0]   <= i_do;
            r_num[0]  <= i_num;
            r_ctx[0]  <= i_ctx;
        end
    end

    for (genvar g = 0; g < QUO_W; g++) begin : g_stage
        logic            bit_in;
        logic [RHO_W:0]  rem_sh;
        logic            ge;
        logic [RHO_W:0]  rem_sub;

        if (QUO_W - 1 - g >= FRAC_BITS) begin : g_data_bit
            assign bit_in = r_low[g][QUO_W - 1 - g - FRAC_BITS];
        end else begin : g_zero_bit
            assign bit_in = 1'b0;
        end

        assign rem_sh  = {r_rem[g], bit_in};
        assign ge      = rem_sh >= {1'b0, r_den[g]};
        assign rem_sub = rem_sh - {1'b0, r_den[g]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g+1] <= 1'b0;
            end else if (i_en) begin
                r_v[g+1] <= r_v[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g+1]  <= ge ? rem_sub[RHO_W-1:0] : rem_sh[RHO_W-1:0];
                r_quo[g+1]  <= {r_quo[g][QUO_W-2:0], ge};
                r_low[g+1]  <= r_low[g];
                r_den[g+1]  <= r_den[g];
                r_neg[g+1]  <= r_neg[g];
                r_zero[g+1] <= r_zero[g];
                r_ovf[g+1]  <= r_ovf[g];
                r_do[g+1]   <= r_do[g];
                r_num[g+1]  <= r_num[g];
                r_ctx[g+1]  <= r_ctx[g];
            end
        end
    end

    always_comb begin
        n_zd = 1'b0;
        n_ov = 1'b0;
        n_q  = r_num[QUO_W];
        if (r_do[QUO_W]) begin
            if (r_zero[QUO_W]) begin
                n_zd = 1'b1;
                n_ov = 1'b1;
                n_q  = r_num[QUO_W][WIDE_W-1] ? WIDE_MIN : WIDE_MAX;
            end else if (r_ovf[QUO_W]) begin
                n_ov = 1'b1;
                n_q  = r_neg[QUO_W] ? WIDE_MIN : WIDE_MAX;
            end else begin
                n_q = r_neg[QUO_W] ? -t_wide'(r_quo[QUO_W]) : t_wide'(r_quo[QUO_W]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_en) begin
            r_o_valid <= r_v[QUO_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_o_q   <= n_q;
            r_o_zd  <= n_zd;
            r_o_ov  <= n_ov;
            r_o_ctx <= r_ctx[QUO_W];
        end
    end

    assign o_valid = r_o_valid;
    assign o_q     = r_o_q;
    assign o_zd    = r_o_zd;
    assign o_ov    = r_o_ov;
    assign o_ctx   = r_o_ctx;

    `VTSU_ASSERT_IMP(a_div_zero_sat, i_clk, i_rst_n, r_o_valid && r_o_zd, r_o_ov)
endmodule

// ----- rtl/velocity_time_step_update_unit.sv -----
// ----------------------------------------------------------------------------
// velocity_time_step_update_unit
// predictor, corrector and three-stage runge-kutta velocity update per cell
// ----------------------------------------------------------------------------
// Takes one cell component per cycle and returns one result per cycle, in
// order, while the result side does not stall; the path runs through the two
// 49-stage restoring dividers (half-time density divide of the runge-kutta
// stages, new density divide of predictor and corrector), each with a setup
// and an output register, plus two 2-stage multipliers and the input and
// output registers. A stall on the result side holds the whole pipeline.
// Registers sit on an APB port at byte address 4*index; write them only
// while no transaction is in flight.
`include "assert_macros.svh"

module velocity_time_step_update_unit (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    vtsu_in_if.sink                   i_in,
    vtsu_out_if.source                o_out,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [vtsu_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);
    import vtsu_pkg::*;

    // configuration registers
    logic [2:0] r_step;
    logic [1:0] r_diff;
    logic       r_adv;
    logic       r_tensor;
    t_rho       r_dt;
    logic [2:0] reg_idx;

    assign reg_idx = paddr[4:2];
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step   <= STEP_PRED;
            r_diff   <= DIFF_EXPL;
            r_adv    <= 1'b0;
            r_tensor <= 1'b0;
            r_dt     <= DT_RESET;
        end else if (psel && penable && pwrite) begin
            case (reg_idx)
                REG_STEP:   r_step   <= pwdata[2:0];
                REG_DIFF:   r_diff   <= pwdata[1:0];
                REG_ADV:    r_adv    <= pwdata[0];
                REG_TENSOR: r_tensor <= pwdata[0];
                REG_DT:     r_dt     <= pwdata[RHO_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_STEP:   prdata = {29'b0, r_step};
            REG_DIFF:   prdata = {30'b0, r_diff};
            REG_ADV:    prdata = {31'b0, r_adv};
            REG_TENSOR: prdata = {31'b0, r_tensor};
            REG_DT:     prdata = {1'b0, r_dt};
            default:    prdata = '0;
        endcase
    end

    logic is_pred, is_corr, is_rk3, is_bypass;
    assign is_pred   = r_step == STEP_PRED;
    assign is_corr   = r_step == STEP_CORR;
    assign is_rk3    = (r_step == STEP_RK1) || (r_step == STEP_RK2) || (r_step == STEP_RK3);
    assign is_bypass = !(is_pred || is_corr || is_rk3);

    // pipeline advances whenever the output register is free or being drained
    logic en;
    logic r_o_valid;
    assign en         = !r_o_valid || o_out.ready;
    assign i_in.ready = en;

    // stage a: input register
    logic  r_a_valid;
    t_data r_a_vn, r_a_vp, r_a_cp, r_a_cn, r_a_f, r_a_dp, r_a_dn;
    t_rho  r_a_rp, r_a_rn, r_a_rh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (en) begin
            r_a_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_vn <= i_in.vel_now;
            r_a_vp <= i_in.vel_prev;
            r_a_cp <= i_in.conv_prev;
            r_a_cn <= i_in.conv_next;
            r_a_f  <= i_in.force_term;
            r_a_dp <= i_in.diff_prev;
            r_a_dn <= i_in.diff_next;
            r_a_rp <= i_in.rho_prev;
            r_a_rn <= i_in.rho_next;
            r_a_rh <= i_in.rho_half;
        end
    end

    // diffusion and convection sums, multiplier operands
    t_wide vn_w, vp_w, cp_w, cn_w, dp_w, dn_w, f_w, vsel, dsel, xsum, tsum;
    t_rho  mul_a_a, mul_b_a, mul_c_a;
    t_wide mul_a_b, mul_b_b;
    t_ctx  n_a_ctx;

    always_comb begin
        vn_w = t_wide'(r_a_vn);
        vp_w = t_wide'(r_a_vp);
        cp_w = t_wide'(r_a_cp);
        cn_w = t_wide'(r_a_cn);
        dp_w = t_wide'(r_a_dp);
        dn_w = t_wide'(r_a_dn);
        f_w  = t_wide'(r_a_f);
        vsel = is_corr ? vp_w : vn_w;

        if (is_pred) begin
            case (r_diff)
                DIFF_EXPL: dsel = dp_w;
                DIFF_CN:   dsel = half_q(dp_w);
                default:   dsel = r_tensor ? dp_w : '0;
            endcase
            xsum = cp_w + dsel;
        end else begin
            case (r_diff)
                DIFF_EXPL: dsel = half_q(dp_w + dn_w);
                DIFF_CN:   dsel = half_q(dp_w);
                default:   dsel = r_tensor ? dn_w : '0;
            endcase
            xsum = half_q(cp_w + cn_w) + dsel;
        end
        tsum = (r_step == STEP_RK1) ? (cp_w + dp_w) : (cn_w + dn_w);

        case (r_step)
            STEP_RK1: begin
                mul_a_a = Q_ONE;
                mul_b_a = '0;
                mul_c_a = Q_ONE;
            end
            STEP_RK2: begin
                mul_a_a = Q_THREE_QUARTER;
                mul_b_a = Q_QUARTER;
                mul_c_a = Q_QUARTER;
            end
            STEP_RK3: begin
                mul_a_a = Q_THIRD;
                mul_b_a = Q_TWO_THIRDS;
                mul_c_a = Q_TWO_THIRDS;
            end
            default: begin
                mul_a_a = r_a_rp;
                mul_b_a = r_a_rh;
                mul_c_a = '0;
            end
        endcase
        mul_a_b = is_rk3 ? vp_w : vsel;
        mul_b_b = is_rk3 ? vn_w : f_w;

        n_a_ctx        = '0;
        n_a_ctx.rk3    = is_rk3;
        n_a_ctx.bypass = is_bypass;
        n_a_ctx.base   = vsel;
        n_a_ctx.sum    = is_rk3 ? tsum : xsum;
        n_a_ctx.frc    = r_a_f;
        n_a_ctx.den    = is_rk3 ? r_a_rh : r_a_rn;
    end

    t_wide mul_a_p, mul_b_p, mul_c_p;
    logic  mul_a_ov, mul_b_ov, mul_c_ov;

    vtsu_mul u_mul_a (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_a(mul_a_a), .i_b(mul_a_b), .o_p(mul_a_p), .o_ov(mul_a_ov)
    );
    vtsu_mul u_mul_b (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_a(mul_b_a), .i_b(mul_b_b), .o_p(mul_b_p), .o_ov(mul_b_ov)
    );
    vtsu_mul u_mul_c (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_a(mul_c_a), .i_b({{(WIDE_W-RHO_W){1'b0}}, r_dt}), .o_p(mul_c_p), .o_ov(mul_c_ov)
    );

    // stages b, c: context beside the first multipliers
    logic r_b_valid, r_c_valid;
    t_ctx r_b_ctx, r_c_ctx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else if (en) begin
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_ctx <= n_a_ctx;
            r_c_ctx <= r_b_ctx;
        end
    end

    t_ctx n_c_ctx;
    t_sat base_s, sum_s;
    logic adv_pc;

    always_comb begin
        n_c_ctx = r_c_ctx;
        adv_pc  = r_adv && !r_c_ctx.bypass;
        base_s  = sat_add(mul_a_p, mul_b_p);
        sum_s   = sat_add(r_c_ctx.sum, adv_pc ? mul_b_p : t_wide'(r_c_ctx.frc));
        if (r_c_ctx.rk3) begin
            n_c_ctx.base = base_s.v;
            n_c_ctx.kdt  = mul_c_p[RHO_W-1:0];
            n_c_ctx.ov   = mul_a_ov || mul_b_ov || mul_c_ov || base_s.ov;
        end else begin
            n_c_ctx.base = adv_pc ? mul_a_p : r_c_ctx.base;
            n_c_ctx.sum  = sum_s.v;
            n_c_ctx.ov   = !r_c_ctx.bypass && (mul_a_ov || mul_b_ov || sum_s.ov);
        end
    end

    // half-time density divide of the runge-kutta stages
    logic  d1_valid, d1_zd, d1_ov;
    t_wide d1_q;
    t_ctx  d1_ctx;

    vtsu_div u_div_half (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_valid(r_c_valid), .i_do(r_c_ctx.rk3 && r_adv),
        .i_num(n_c_ctx.sum), .i_den(r_c_ctx.den), .i_ctx(n_c_ctx),
        .o_valid(d1_valid), .o_q(d1_q), .o_zd(d1_zd), .o_ov(d1_ov), .o_ctx(d1_ctx)
    );

    t_sat  t_s;
    t_rho  mul_d_a;
    t_wide mul_d_b;
    t_ctx  n_e_ctx;

    always_comb begin
        t_s     = sat_add(d1_q, t_wide'(d1_ctx.frc));
        n_e_ctx = d1_ctx;
        n_e_ctx.zd = d1_zd;
        if (d1_ctx.rk3) begin
            mul_d_a    = d1_ctx.kdt;
            mul_d_b    = t_s.v;
            n_e_ctx.ov = d1_ctx.ov || d1_ov || t_s.ov;
        end else begin
            mul_d_a    = d1_ctx.bypass ? '0 : r_dt;
            mul_d_b    = d1_q;
            n_e_ctx.ov = d1_ctx.ov;
        end
    end

    t_wide mul_d_p;
    logic  mul_d_ov;

    vtsu_mul u_mul_d (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_a(mul_d_a), .i_b(mul_d_b), .o_p(mul_d_p), .o_ov(mul_d_ov)
    );

    // stages f, g: context beside the time step multiplier
    logic r_f_valid, r_g_valid;
    t_ctx r_f_ctx, r_g_ctx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_valid <= 1'b0;
            r_g_valid <= 1'b0;
        end else if (en) begin
            r_f_valid <= d1_valid;
            r_g_valid <= r_f_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f_ctx <= n_e_ctx;
            r_g_ctx <= r_f_ctx;
        end
    end

    t_sat res_s;
    t_ctx n_g_ctx;

    always_comb begin
        res_s      = sat_add(r_g_ctx.base, mul_d_p);
        n_g_ctx    = r_g_ctx;
        n_g_ctx.ov = r_g_ctx.ov || mul_d_ov || res_s.ov;
    end

    // new density divide of predictor and corrector
    logic  d2_valid, d2_zd, d2_ov;
    t_wide d2_q;
    t_ctx  d2_ctx;

    vtsu_div u_div_next (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_valid(r_g_valid), .i_do(!r_g_ctx.rk3 && !r_g_ctx.bypass && r_adv),
        .i_num(res_s.v), .i_den(r_g_ctx.den), .i_ctx(n_g_ctx),
        .o_valid(d2_valid), .o_q(d2_q), .o_zd(d2_zd), .o_ov(d2_ov), .o_ctx(d2_ctx)
    );

    // final clip to the data width
    localparam t_wide DATA_MAX = t_wide'({1'b0, {(DATA_WIDTH-1){1'b1}}});
    localparam t_wide DATA_MIN = -DATA_MAX - t_wide'(1);

    t_data n_res;
    logic  n_zd, n_sat;

    always_comb begin
        n_zd  = d2_ctx.zd || d2_zd;
        n_sat = d2_ctx.ov || d2_ov;
        if (d2_q > DATA_MAX) begin
            n_res = DATA_MAX[DATA_WIDTH-1:0];
            n_sat = 1'b1;
        end else if (d2_q < DATA_MIN) begin
            n_res = DATA_MIN[DATA_WIDTH-1:0];
            n_sat = 1'b1;
        end else begin
            n_res = d2_q[DATA_WIDTH-1:0];
        end
        if (d2_ctx.bypass) begin
            n_zd  = 1'b0;
            n_sat = 1'b0;
        end
    end

    t_data r_o_res;
    logic  r_o_zd, r_o_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (en) begin
            r_o_valid <= d2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_o_res <= n_res;
            r_o_zd  <= n_zd;
            r_o_sat <= n_sat;
        end
    end

    assign o_out.valid        = r_o_valid;
    assign o_out.vel_result   = r_o_res;
    assign o_out.zero_density = r_o_zd;
    assign o_out.saturated    = r_o_sat;

    `VTSU_ASSERT_IMP(a_zd_implies_sat, i_clk, i_rst_n, r_o_valid && r_o_zd, r_o_sat)
    `VTSU_ASSERT_NEXT(a_stall_holds_result, i_clk, i_rst_n, r_o_valid && !o_out.ready, r_o_valid && $stable(r_o_res))
    `VTSU_ASSERT_NEXT(a_div_out_when_busy, i_clk, i_rst_n, d2_valid && !en, $stable(d2_q))
endmodule
